FILE: sv/rowp_pkg.sv
// Shared types and constants of the row message parser.
// Used by the parser core, the result queue and the top level.
package rowp_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_NULL    = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;
  localparam logic [1:0] KIND_STATUS  = 2'd3;

  // Message status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
  localparam logic [2:0] ST_SHORT_HDR  = 3'd2;
  localparam logic [2:0] ST_WRAP       = 3'd3;
  localparam logic [2:0] ST_SHORT_DATA = 3'd4;
  localparam logic [2:0] ST_TRAILING   = 3'd5;

  localparam logic [31:0] NULL_LEN  = 32'hFFFF_FFFF;
  localparam int          LEN_BYTES = 4;

  // Default depth of the result queue; at least two entries.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] attr_index;
    logic [7:0]  payload_byte;
    logic        attr_end;
    logic [2:0]  status_code;
    logic [15:0] attr_count;
    logic        last_of_run;
  } res_t;

  // Results produced by one accepted byte: up to two, in order.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

FILE: sv/rowp_ifs.sv
// Handshake interfaces for the byte input channel and the result channel.
// Does not refer to rowp_pkg; its field widths are declared here and match res_t there.
interface rowp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface rowp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] attr_index;
  logic [7:0]  payload_byte;
  logic        attr_end;
  logic [2:0]  status_code;
  logic [15:0] attr_count;
  logic        last_of_run;

  modport source (output valid, output result_kind, output attr_index, output payload_byte,
                  output attr_end, output status_code, output attr_count,
                  output last_of_run, input ready);
  modport sink (input valid, input result_kind, input attr_index, input payload_byte,
                input attr_end, input status_code, input attr_count,
                input last_of_run, output ready);
endinterface

FILE: sv/rowp_core.sv
// Parser state and the combinational step logic for one message byte.
// Depends on rowp_pkg for result types and status codes.
module rowp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               end_of_message,
  output rowp_pkg::push_t    push
);

  localparam logic [2:0] PH_CNT0  = 3'd0;
  localparam logic [2:0] PH_CNT1  = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_DRAIN = 3'd4;

  localparam logic [1:0] LAST_FBI = 2'(rowp_pkg::LEN_BYTES - 1);

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  fbi_r, fbi_nxt;
  logic [15:0] exp_r, exp_nxt;
  logic [15:0] done_r, done_nxt;
  logic [31:0] lacc_r, lacc_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [2:0]  err_r, err_nxt;

  logic          prim_en, stat_en, complete;
  logic [2:0]    stat_code;
  logic [32:0]   end_sum;
  rowp_pkg::res_t prim, stat;

  always_comb begin
    phase_nxt = phase_r;
    fbi_nxt   = fbi_r;
    exp_nxt   = exp_r;
    done_nxt  = done_r;
    lacc_nxt  = lacc_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    err_nxt   = err_r;
    prim_en   = 1'b0;
    prim      = '0;
    stat_en   = 1'b0;
    stat_code = rowp_pkg::ST_OK;
    stat      = '0;
    complete  = 1'b0;
    end_sum   = '0;

    case (phase_r)
      PH_CNT1: begin
        exp_nxt = {exp_r[7:0], data_byte};
        if (end_of_message) begin
          stat_en   = 1'b1;
          stat_code = (exp_nxt == 16'd0) ? rowp_pkg::ST_OK : rowp_pkg::ST_SHORT_HDR;
        end else if (exp_nxt == 16'd0) begin
          err_nxt   = rowp_pkg::ST_TRAILING;
          phase_nxt = PH_DRAIN;
        end else begin
          phase_nxt = PH_LEN;
          fbi_nxt   = '0;
          lacc_nxt  = '0;
        end
      end
      PH_LEN: begin
        lacc_nxt = {lacc_r[23:0], data_byte};
        pos_nxt  = pos_r + 32'd1;
        end_sum  = {1'b0, pos_nxt} + {1'b0, lacc_nxt};
        if (fbi_r != LAST_FBI) begin
          fbi_nxt = fbi_r + 2'd1;
          if (end_of_message) begin
            stat_en   = 1'b1;
            stat_code = rowp_pkg::ST_SHORT_HDR;
          end
        end else begin
          fbi_nxt = '0;
          if (lacc_nxt == rowp_pkg::NULL_LEN) begin
            prim_en          = 1'b1;
            prim.result_kind = rowp_pkg::KIND_NULL;
            prim.attr_index  = done_r;
            complete         = 1'b1;
          end else if (end_sum[32]) begin
            if (end_of_message) begin
              stat_en   = 1'b1;
              stat_code = rowp_pkg::ST_WRAP;
            end else begin
              err_nxt   = rowp_pkg::ST_WRAP;
              phase_nxt = PH_DRAIN;
            end
          end else if (lacc_nxt == 32'd0) begin
            prim_en          = 1'b1;
            prim.result_kind = rowp_pkg::KIND_EMPTY;
            prim.attr_index  = done_r;
            complete         = 1'b1;
          end else begin
            left_nxt  = lacc_nxt;
            phase_nxt = PH_DATA;
            if (end_of_message) begin
              stat_en   = 1'b1;
              stat_code = rowp_pkg::ST_SHORT_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        pos_nxt           = pos_r + 32'd1;
        prim_en           = 1'b1;
        prim.result_kind  = rowp_pkg::KIND_PAYLOAD;
        prim.attr_index   = done_r;
        prim.payload_byte = data_byte;
        prim.attr_end     = (left_r == 32'd1);
        left_nxt          = left_r - 32'd1;
        if (left_nxt == 32'd0) begin
          complete = 1'b1;
        end else if (end_of_message) begin
          stat_en   = 1'b1;
          stat_code = rowp_pkg::ST_SHORT_DATA;
        end
      end
      PH_DRAIN: begin
        if (end_of_message) begin
          stat_en   = 1'b1;
          stat_code = err_r;
        end
      end
      default: begin
        if (end_of_message) begin
          stat_en   = 1'b1;
          stat_code = rowp_pkg::ST_TOO_SHORT;
        end else begin
          exp_nxt   = {8'd0, data_byte};
          phase_nxt = PH_CNT1;
        end
      end
    endcase

    // Attribute finished: either the message ends here, or more follow, or
    // everything after the last expected attribute is trailing garbage.
    if (complete) begin
      done_nxt = done_r + 16'd1;
      if (end_of_message) begin
        stat_en   = 1'b1;
        stat_code = (done_nxt == exp_nxt) ? rowp_pkg::ST_OK : rowp_pkg::ST_SHORT_HDR;
      end else if (done_nxt == exp_nxt) begin
        err_nxt   = rowp_pkg::ST_TRAILING;
        phase_nxt = PH_DRAIN;
      end else begin
        phase_nxt = PH_LEN;
        fbi_nxt   = '0;
        lacc_nxt  = '0;
      end
    end

    stat.result_kind = rowp_pkg::KIND_STATUS;
    stat.attr_index  = done_nxt;
    stat.status_code = stat_code;
    stat.attr_count  = done_nxt;
    stat.last_of_run = 1'b1;

    // A status always closes out the message and returns to the count header.
    if (stat_en) begin
      phase_nxt = PH_CNT0;
      fbi_nxt   = '0;
      exp_nxt   = '0;
      done_nxt  = '0;
      lacc_nxt  = '0;
      left_nxt  = '0;
      pos_nxt   = '0;
      err_nxt   = rowp_pkg::ST_OK;
    end

    prim.last_of_run = !stat_en;
    push.cnt = accept ? ({1'b0, prim_en} + {1'b0, stat_en}) : 2'd0;
    push.r0  = prim_en ? prim : stat;
    push.r1  = stat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CNT0;
      fbi_r   <= '0;
      exp_r   <= '0;
      done_r  <= '0;
      lacc_r  <= '0;
      left_r  <= '0;
      pos_r   <= '0;
      err_r   <= rowp_pkg::ST_OK;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fbi_r   <= fbi_nxt;
      exp_r   <= exp_nxt;
      done_r  <= done_nxt;
      lacc_r  <= lacc_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fbi_len_only: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_LEN |-> fbi_r == 2'd0)
    else $error("header byte index left nonzero outside a length header");

  a_drain_err: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DRAIN |-> (err_r == rowp_pkg::ST_WRAP || err_r == rowp_pkg::ST_TRAILING))
    else $error("drain phase without a latched error");

  a_err_drain_only: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != rowp_pkg::ST_OK |-> phase_r == PH_DRAIN)
    else $error("latched error outside the drain phase");

  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> left_r != 32'd0)
    else $error("payload phase with no bytes left");

  a_eom_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_message |=> phase_r == PH_CNT0 && done_r == 16'd0)
    else $error("parser did not restart after the final byte");
`endif

endmodule

FILE: sv/rowp_queue.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
// Depends on rowp_pkg for the result and push types.
module rowp_queue #(
  parameter int DEPTH = rowp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rowp_pkg::push_t  push,
  output logic             space_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output rowp_pkg::res_t   out_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rowp_pkg::res_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_1;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    bump = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rp_r];
  // Room for the worst case of two results from the next byte.
  assign space_ok  = (cnt_r <= CW'(DEPTH - 2));
  assign wp_1      = bump(wp_r);

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = pop ? bump(rp_r) : rp_r;
    cnt_nxt = cnt_r + CW'(push.cnt) - CW'(pop);
    if (push.cnt == 2'd1) begin
      wp_nxt = wp_1;
    end else if (push.cnt == 2'd2) begin
      wp_nxt = bump(wp_1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp_1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> $past(cnt_r) <= CW'(DEPTH) && cnt_r <= CW'(DEPTH - 2))
    else $error("results pushed without room in the queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(!rst_n) && $past(push.cnt) == 2'd0 && !$past(pop) |-> $stable(cnt_r))
    else $error("queue count changed without a push or pop");
`endif

endmodule

FILE: sv/length_prefixed_row_parser_top.sv
// A result is registered into the result queue when the byte that causes it is accepted and is
// offered on out_chan from the queue head. Throughput: one message byte per cycle while each
// byte yields at most one result and the consumer keeps up; two results from one byte leave
// one at a time, and input flows on while the queue (default four entries) has room for two.
// Reset (rst_n low, synchronous) returns the parser to the count header and empties the queue.
// Top level of the row message parser: parser core plus result queue.
module length_prefixed_row_parser_top #(
  parameter int QUEUE_DEPTH = rowp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  rowp_in_if.sink        in_chan,
  rowp_out_if.source     out_chan
);

  // The core updates its state on every accepted byte and produces up to
  // two results (an attribute result and/or the message status) in the
  // same cycle; the queue stores both and hands them out one per request.
  rowp_pkg::push_t push;
  rowp_pkg::res_t  head;
  logic            space_ok;
  logic            in_accept;

  // Input is taken whenever the queue could absorb two more results, so with three or more
  // entries a finished result waiting on the output never blocks the next byte by itself.
  assign in_chan.ready = space_ok;
  assign in_accept     = in_chan.valid && space_ok;

  rowp_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .data_byte      (in_chan.data_byte),
    .end_of_message (in_chan.end_of_message),
    .push           (push)
  );

  rowp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (head)
  );

  // Unpack the queue head onto the result channel fields.
  assign out_chan.result_kind  = head.result_kind;
  assign out_chan.attr_index   = head.attr_index;
  assign out_chan.payload_byte = head.payload_byte;
  assign out_chan.attr_end     = head.attr_end;
  assign out_chan.status_code  = head.status_code;
  assign out_chan.attr_count   = head.attr_count;
  assign out_chan.last_of_run  = head.last_of_run;

endmodule
